// File: design/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg: shared types and constants for the rational add-reduce block
// Payload widths, the front-to-back queue entry and the back-end states.
// ----------------------------------------------------------------------------
package rar_pkg;

   localparam int IN_WIDTH_DEF = 16;
   localparam int NUM_W        = 33;
   localparam int DEN_W        = 32;
   // magnitude width wide enough for a sum of two products at the widest input
   localparam int MAG_W        = 65;
   localparam int CNT_W        = 7;   // counts up to MAG_W bit steps
   localparam int QDEPTH       = 2;

   typedef struct packed {
      logic             err;      // zero input denominator
      logic             zero;     // cross sum is zero
      logic             num_neg;
      logic [MAG_W-1:0] num_mag;
      logic             den_neg;
      logic [MAG_W-1:0] den_mag;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_QNUM,
      ST_QDEN,
      ST_DONE
   } state_type;

endpackage

// File: design/rar_if.sv
// ----------------------------------------------------------------------------
// rar_if: valid/ready channel
// Carries one payload type between a source and a sink.
// ----------------------------------------------------------------------------
interface rar_if #(parameter type T = logic);
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: design/rar_front.sv
// ----------------------------------------------------------------------------
// rar_front: input stage
// Registers an item, forms the cross products and sum, classifies it, and
// pushes a job into a small queue toward the back end.
// ----------------------------------------------------------------------------
module rar_front import rar_pkg::*; #(
   parameter int IN_WIDTH = IN_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [IN_WIDTH-1:0] a_num,
   input  logic [IN_WIDTH-1:0] a_den,
   input  logic [IN_WIDTH-1:0] b_num,
   input  logic [IN_WIDTH-1:0] b_den,
   output logic                job_valid,
   input  logic                job_ready,
   output job_type             job
);
   localparam int PW = 2*IN_WIDTH;

   // stage 1: input register with magnitudes
   logic                s1_ff, s1_in;
   logic [IN_WIDTH-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic [3:0]          sg_ff;
   // stage 2: products
   logic                s2_ff, s2_in;
   logic [PW-1:0]       p1_ff, p2_ff, pd_ff;
   logic                p1n_ff, p2n_ff, pdn_ff, err_ff;
   // queue
   job_type             q_ff [QDEPTH];
   logic [1:0]          cnt_ff;
   logic                wp_ff, rp_ff;

   logic                push, pop, adv2, adv1;
   job_type             nj;
   logic [MAG_W-1:0]    m1, m2;

   function automatic logic [IN_WIDTH-1:0] mag(input logic [IN_WIDTH-1:0] v);
      mag = v[IN_WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

   assign pop       = job_valid && job_ready;
   assign push      = s2_ff && (cnt_ff != 2'(QDEPTH) || pop);
   assign adv2      = !s2_ff || push;
   assign adv1      = !s1_ff || adv2;
   assign in_ready  = adv1;
   assign s1_in     = (in_valid && in_ready) ? 1'b1 : (adv2 ? 1'b0 : s1_ff);
   assign s2_in     = adv2 ? s1_ff : s2_ff;
   assign job_valid = cnt_ff != 2'd0;
   assign job       = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
         cnt_ff <= 2'd0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         an_ff <= mag(a_num);
         ad_ff <= mag(a_den);
         bn_ff <= mag(b_num);
         bd_ff <= mag(b_den);
         sg_ff <= {a_num[IN_WIDTH-1], a_den[IN_WIDTH-1],
                   b_num[IN_WIDTH-1], b_den[IN_WIDTH-1]};
      end
      if (adv2 && s1_ff) begin
         p1_ff  <= PW'(an_ff) * PW'(bd_ff);
         p2_ff  <= PW'(bn_ff) * PW'(ad_ff);
         pd_ff  <= PW'(ad_ff) * PW'(bd_ff);
         p1n_ff <= sg_ff[3] ^ sg_ff[0];
         p2n_ff <= sg_ff[1] ^ sg_ff[2];
         pdn_ff <= sg_ff[2] ^ sg_ff[0];
         err_ff <= (ad_ff == '0) || (bd_ff == '0);
      end
      if (push) q_ff[wp_ff] <= nj;
   end

   // signed add of the two products in sign-magnitude form
   always_comb begin
      m1 = MAG_W'(p1_ff);
      m2 = MAG_W'(p2_ff);
      nj.err     = err_ff;
      nj.den_neg = pdn_ff;
      nj.den_mag = MAG_W'(pd_ff);
      if (p1n_ff == p2n_ff) begin
         nj.num_mag = m1 + m2;
         nj.num_neg = p1n_ff;
      end else if (m1 >= m2) begin
         nj.num_mag = m1 - m2;
         nj.num_neg = p1n_ff;
      end else begin
         nj.num_mag = m2 - m1;
         nj.num_neg = p2n_ff;
      end
      nj.zero = nj.num_mag == '0;
      if (nj.zero) nj.num_neg = 1'b0;
   end

`ifndef SYNTHESIS
   a_qbound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QDEPTH)) else $error("queue overflow");
   a_nopush_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'(QDEPTH) && !pop) |-> !push) else $error("push into full queue");
   a_valid_cnt: assert property (@(posedge clock) disable iff (reset)
      job_valid == (cnt_ff != 2'd0)) else $error("job valid mismatch");
`endif

endmodule

// File: design/rar_back.sv
// ----------------------------------------------------------------------------
// rar_back: reduction engine
// Runs Euclid with a bit-serial restoring divider, then divides both parts
// by the final divisor with the same divider, and holds the result; error and zero-sum jobs skip the division.
// ----------------------------------------------------------------------------
module rar_back import rar_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  job_type           job,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [NUM_W-1:0]  sum_num,
   output logic [DEN_W-1:0]  sum_den,
   output logic              zero_den_error
);
   state_type        st_ff, st_in;
   job_type          j_ff;
   logic [MAG_W-1:0] dd_ff, dv_ff;      // dividend, divisor magnitudes
   logic             dvn_ff;            // divisor sign
   logic             dds_ff;            // dividend sign
   logic [MAG_W-1:0] rm_ff, qt_ff;      // divider partial remainder, quotient
   logic [CNT_W-1:0] k_ff;
   logic [MAG_W-1:0] qn_ff;
   logic             ov_ff;
   logic [NUM_W-1:0] on_ff;
   logic [DEN_W-1:0] od_ff;
   logic             oe_ff;

   logic [MAG_W:0]   trial;
   logic [MAG_W-1:0] rsh, q_next, r_next;
   logic             num_gt, take, last;

   // signed compare num > den
   always_comb begin
      if (job.num_neg != job.den_neg) num_gt = job.den_neg;
      else if (job.num_neg)           num_gt = job.num_mag < job.den_mag;
      else                            num_gt = job.num_mag > job.den_mag;
   end

   // one restoring step: shift in next dividend bit
   always_comb begin
      rsh    = {rm_ff[MAG_W-2:0], qt_ff[MAG_W-1]};
      trial  = {1'b0, rsh} - {1'b0, dv_ff};
      r_next = trial[MAG_W] ? rsh : trial[MAG_W-1:0];
      q_next = {qt_ff[MAG_W-2:0], ~trial[MAG_W]};
      last   = k_ff == CNT_W'(MAG_W-1);
   end

   assign take      = job_valid && job_ready;
   assign job_ready = (st_ff == ST_IDLE) && (!ov_ff || out_ready);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (take) st_in = (job.err || job.zero) ? ST_DONE : ST_LOAD;
         ST_LOAD: st_in = ST_DIV;
         ST_DIV:  if (last) st_in = (r_next == '0) ? ST_QNUM : ST_DIV;
         ST_QNUM: if (last) st_in = ST_QDEN;
         ST_QDEN: if (last) st_in = ST_DONE;
         ST_DONE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == ST_DONE) ov_ff <= 1'b1;
         else if (out_ready)   ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      unique case (st_ff)
         ST_IDLE: if (take) begin
            j_ff <= job;
            if (num_gt) begin
               dd_ff <= job.num_mag; dv_ff <= job.den_mag; dvn_ff <= job.den_neg;
               dds_ff <= job.num_neg;
            end else begin
               dd_ff <= job.den_mag; dv_ff <= job.num_mag; dvn_ff <= job.num_neg;
               dds_ff <= job.den_neg;
            end
         end
         ST_LOAD: begin
            rm_ff <= '0; qt_ff <= dd_ff; k_ff <= '0;
         end
         ST_DIV: begin
            rm_ff <= r_next; qt_ff <= q_next; k_ff <= k_ff + 1'b1;
            if (last) begin
               k_ff <= '0;
               rm_ff <= '0;
               if (r_next == '0) begin
                  qt_ff <= j_ff.num_mag;
               end else begin
                  // remainder takes dividend sign; divisor becomes new dividend
                  dd_ff <= dv_ff; dv_ff <= r_next;
                  qt_ff <= dv_ff;
                  dds_ff <= dvn_ff;
                  dvn_ff <= dds_ff;
               end
            end
         end
         ST_QNUM: begin
            rm_ff <= r_next; qt_ff <= q_next; k_ff <= k_ff + 1'b1;
            if (last) begin
               qn_ff <= q_next; k_ff <= '0; rm_ff <= '0; qt_ff <= j_ff.den_mag;
            end
         end
         ST_QDEN: begin
            rm_ff <= r_next; qt_ff <= q_next; k_ff <= k_ff + 1'b1;
            if (last) begin
               on_ff <= NUM_W'((j_ff.num_neg ^ dvn_ff) ? (~qn_ff + 1'b1) : qn_ff);
               od_ff <= DEN_W'((j_ff.den_neg ^ dvn_ff) ? (~q_next + 1'b1) : q_next);
               oe_ff <= 1'b0;
            end
         end
         ST_DONE: if (j_ff.err || j_ff.zero) begin
            on_ff <= '0; od_ff <= DEN_W'(1); oe_ff <= j_ff.err;
         end
         default: ;
      endcase
   end

   assign out_valid      = ov_ff;
   assign sum_num        = on_ff;
   assign sum_den        = od_ff;
   assign zero_den_error = oe_ff;

`ifndef SYNTHESIS
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_IDLE) |-> !job_ready) else $error("accepted while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_DIV) |-> (k_ff < CNT_W'(MAG_W))) else $error("step count");
`endif

endmodule

// File: design/rational_add_reduce_top.sv
// ----------------------------------------------------------------------------
// rational_add_reduce_top: adds two fractions and reduces the sum
// Front end forms the cross products; back end reduces by Euclid.
// ----------------------------------------------------------------------------
// Zero-denominator and zero-sum items skip the divider; other items run one
//   bit-serial restoring division per Euclid remainder step, then two more
//   for the reduced numerator and denominator, all on the shared divider.
// The back end takes a new item only once it has finished the previous one.
// Reset: synchronous, active high; clears valid bits, queue and state.
module rational_add_reduce_top import rar_pkg::*; #(
   parameter int IN_WIDTH = IN_WIDTH_DEF
) (
   input  logic  clock,
   input  logic  reset,
   rar_if.sink   req,
   rar_if.source rsp
);
   logic    job_valid, job_ready;
   job_type job;

   // front: register, multiply, classify, queue
   rar_front #(.IN_WIDTH(IN_WIDTH)) u_front (
      .clock, .reset,
      .in_valid (req.valid),
      .in_ready (req.ready),
      .a_num    (req.data.a_num),
      .a_den    (req.data.a_den),
      .b_num    (req.data.b_num),
      .b_den    (req.data.b_den),
      .job_valid, .job_ready, .job
   );

   // back: Euclid reduction and output register
   rar_back u_back (
      .clock, .reset,
      .job_valid, .job_ready, .job,
      .out_valid      (rsp.valid),
      .out_ready      (rsp.ready),
      .sum_num        (rsp.data.sum_num),
      .sum_den        (rsp.data.sum_den),
      .zero_den_error (rsp.data.zero_den_error)
   );
endmodule
